>>> sv/cthm_pkg.sv
// ----------------------------------------------------------------------------
// cthm_pkg
// Shared types and constants of the cache tag hit/miss model: geometry of the
// tag store, register indexes and associativity codes.
// ----------------------------------------------------------------------------
package cthm_pkg;

  // Geometry of the line store
  localparam int unsigned LINES    = 1024;
  localparam int unsigned MAX_WAYS = 4;
  localparam int unsigned ROWS     = LINES / MAX_WAYS;
  localparam int unsigned ROW_AW   = $clog2(ROWS);
  localparam int unsigned SET_W    = $clog2(LINES);
  localparam int unsigned SLOT_W   = $clog2(MAX_WAYS);

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned LFSR_W   = 16;

  // Largest usable index width per associativity
  localparam int unsigned IB_MAX_1WAY = SET_W;
  localparam int unsigned IB_MAX_2WAY = SET_W - 1;
  localparam int unsigned IB_MAX_4WAY = SET_W - 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd2;

  // Associativity codes; the unused code behaves as direct mapped
  localparam logic [1:0] ASSOC_DIRECT = 2'd0;
  localparam logic [1:0] ASSOC_FOUR   = 2'd1;
  localparam logic [1:0] ASSOC_TWO    = 2'd2;

  localparam logic [1:0]        ASSOC_RESET  = ASSOC_DIRECT;
  localparam logic [3:0]        OFFSET_RESET = 4'd5;
  localparam logic [3:0]        INDEX_RESET  = 4'd3;
  localparam logic [LFSR_W-1:0] LFSR_SEED    = 16'hACE1;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } slot_t;

  // One memory row holds MAX_WAYS consecutive lines
  typedef slot_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    row_t              data;
  } ram_wr_t;

endpackage

>>> sv/cthm_tag_ram.sv
// ----------------------------------------------------------------------------
// cthm_tag_ram
// Tag/valid row memory with a registered read port and one write port.
// A write to the row read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module cthm_tag_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [cthm_pkg::ROW_AW-1:0]   rd_addr_i,
  output cthm_pkg::row_t                rd_data_o,
  input  cthm_pkg::ram_wr_t             wr_i
);

  cthm_pkg::row_t mem [cthm_pkg::ROWS];
  cthm_pkg::row_t rd_q;
  cthm_pkg::row_t fwd_data_q;
  logic           fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    fwd_data_q <= wr_i.data;
  end

  // Remember a same-row collision so the fresh row wins over the stale read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= rd_en_i && wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> sv/cache_tag_hit_miss_model_unit.sv
// ----------------------------------------------------------------------------
// cache_tag_hit_miss_model_unit
// Result: the access is registered into stage 1 and done_o is registered from
//   the stage 1 valid flag; hit_o / hit_total_o / miss_total_o
//   hold the result for the single done cycle.
// Throughput: one access per cycle; busy_o stays low. The tag RAM read is
//   registered and its write-back is forwarded to a same-row read.
// Reset: counters, LFSR and row flags clear at once; no clearing pass.
//   The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module cache_tag_hit_miss_model_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // access command
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [cthm_pkg::ADDR_W-1:0]       address_i,
  input  logic                              op_i,
  // result
  output logic                              done_o,
  output logic                              hit_o,
  output logic [cthm_pkg::CNT_W-1:0]        hit_total_o,
  output logic [cthm_pkg::CNT_W-1:0]        miss_total_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cthm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cthm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0] assoc_mode_q;
  logic [3:0] offset_bits_q;
  logic [3:0] index_bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assoc_mode_q  <= cthm_pkg::ASSOC_RESET;
      offset_bits_q <= cthm_pkg::OFFSET_RESET;
      index_bits_q  <= cthm_pkg::INDEX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Writes to indexes beyond the register list are dropped
      unique case (cfg_index_i)
        cthm_pkg::CFG_ASSOC_MODE:  assoc_mode_q  <= cfg_wdata_i[1:0];
        cthm_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i[3:0];
        cthm_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Lookup stage 0: split the address, pick the row, launch the RAM read
  // --------------------------------------------------------------------------
  logic                             accept;
  logic [cthm_pkg::SLOT_W-1:0]      ways_m1;   // ways minus one: 0, 1 or 3
  logic [3:0]                       ib_max;
  logic [3:0]                       ib;
  logic [cthm_pkg::ADDR_W-1:0]      set_mask;
  logic [cthm_pkg::ADDR_W-1:0]      set_full;
  logic [cthm_pkg::SET_W-1:0]       set_idx;
  logic [4:0]                       tag_shift;
  logic [cthm_pkg::TAG_W-1:0]       tag;
  logic [cthm_pkg::ROW_AW-1:0]      row;
  logic [cthm_pkg::SLOT_W-1:0]      base;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    unique case (assoc_mode_q)
      cthm_pkg::ASSOC_FOUR: begin
        ways_m1 = cthm_pkg::SLOT_W'(3);
        ib_max  = 4'(cthm_pkg::IB_MAX_4WAY);
      end
      cthm_pkg::ASSOC_TWO: begin
        ways_m1 = cthm_pkg::SLOT_W'(1);
        ib_max  = 4'(cthm_pkg::IB_MAX_2WAY);
      end
      default: begin
        ways_m1 = cthm_pkg::SLOT_W'(0);
        ib_max  = 4'(cthm_pkg::IB_MAX_1WAY);
      end
    endcase

    // Saturate the index width at what the set count allows
    ib        = (index_bits_q > ib_max) ? ib_max : index_bits_q;
    set_mask  = (cthm_pkg::ADDR_W'(1) << ib) - cthm_pkg::ADDR_W'(1);
    set_full  = (address_i >> offset_bits_q) & set_mask;
    set_idx   = set_full[cthm_pkg::SET_W-1:0];
    tag_shift = 5'(offset_bits_q) + 5'(ib);
    tag       = cthm_pkg::TAG_W'(address_i >> tag_shift);

    // Line s*ways+w lives in row (s*ways+w)/MAX_WAYS
    unique case (assoc_mode_q)
      cthm_pkg::ASSOC_FOUR: begin
        row  = set_idx[cthm_pkg::ROW_AW-1:0];
        base = '0;
      end
      cthm_pkg::ASSOC_TWO: begin
        row  = set_idx[cthm_pkg::ROW_AW:1];
        base = {set_idx[0], 1'b0};
      end
      default: begin
        row  = set_idx[cthm_pkg::SET_W-1:cthm_pkg::SLOT_W];
        base = set_idx[cthm_pkg::SLOT_W-1:0];
      end
    endcase
  end

  logic                             s1_valid_q;
  logic                             s1_write_q;
  logic [cthm_pkg::ROW_AW-1:0]      s1_row_q;
  logic [cthm_pkg::SLOT_W-1:0]      s1_base_q;
  logic [cthm_pkg::SLOT_W-1:0]      s1_ways_m1_q;
  logic [cthm_pkg::TAG_W-1:0]       s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_write_q   <= op_i;
      s1_row_q     <= row;
      s1_base_q    <= base;
      s1_ways_m1_q <= ways_m1;
      s1_tag_q     <= tag;
    end
  end

  // --------------------------------------------------------------------------
  // Tag RAM
  // --------------------------------------------------------------------------
  cthm_pkg::row_t    ram_rd_data;
  cthm_pkg::ram_wr_t ram_wr;

  cthm_tag_ram u_tag_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (row),
    .rd_data_o (ram_rd_data),
    .wr_i      (ram_wr)
  );

  // --------------------------------------------------------------------------
  // Lookup stage 1: compare, choose victim, write back, update totals
  // --------------------------------------------------------------------------
  // A row never written since reset reads as all lines invalid
  logic [cthm_pkg::ROWS-1:0]    row_init_q;
  logic [cthm_pkg::ROWS-1:0]    row_init_d;
  logic [cthm_pkg::LFSR_W-1:0]  lfsr_q;
  logic [cthm_pkg::LFSR_W-1:0]  lfsr_d;
  logic [cthm_pkg::CNT_W-1:0]   hit_cnt_q;
  logic [cthm_pkg::CNT_W-1:0]   hit_cnt_d;
  logic [cthm_pkg::CNT_W-1:0]   miss_cnt_q;
  logic [cthm_pkg::CNT_W-1:0]   miss_cnt_d;
  logic                         done_q;
  logic                         hit_q;

  cthm_pkg::row_t               cur_row;
  cthm_pkg::row_t               new_row;
  logic                         lookup_hit;
  logic                         free_found;
  logic [cthm_pkg::SLOT_W-1:0]  victim;
  logic [cthm_pkg::SLOT_W-1:0]  victim_slot;
  logic                         lfsr_fb;

  always_comb begin
    logic [cthm_pkg::SLOT_W-1:0] slot;
    logic                        active;

    cur_row = ram_rd_data;
    if (!row_init_q[s1_row_q]) begin
      for (int s = 0; s < cthm_pkg::MAX_WAYS; s++) begin
        cur_row[s].valid = 1'b0;
      end
    end

    lookup_hit = 1'b0;
    free_found = 1'b0;
    victim     = '0;
    for (int w = 0; w < cthm_pkg::MAX_WAYS; w++) begin
      slot   = s1_base_q + cthm_pkg::SLOT_W'(w);
      active = (cthm_pkg::SLOT_W'(w) <= s1_ways_m1_q);
      if (active && cur_row[slot].valid && (cur_row[slot].tag == s1_tag_q)) begin
        lookup_hit = 1'b1;
      end
      // First invalid way takes the fill
      if (active && !cur_row[slot].valid && !free_found) begin
        free_found = 1'b1;
        victim     = cthm_pkg::SLOT_W'(w);
      end
    end

    lfsr_fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
    lfsr_d  = lfsr_q;
    if (!free_found) begin
      victim = lfsr_q[cthm_pkg::SLOT_W-1:0] & s1_ways_m1_q;
    end
    victim_slot = s1_base_q + victim;

    new_row                   = cur_row;
    new_row[victim_slot].valid = 1'b1;
    new_row[victim_slot].tag   = s1_tag_q;

    ram_wr.en   = s1_valid_q && s1_write_q && !lookup_hit;
    ram_wr.addr = s1_row_q;
    ram_wr.data = new_row;

    // Advance the LFSR only on a replacement of a full set
    if (ram_wr.en && !free_found) begin
      lfsr_d = {lfsr_fb, lfsr_q[cthm_pkg::LFSR_W-1:1]};
    end

    row_init_d = row_init_q;
    if (ram_wr.en) begin
      row_init_d[s1_row_q] = 1'b1;
    end

    // Saturating totals
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (s1_valid_q) begin
      if (lookup_hit) begin
        if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + cthm_pkg::CNT_W'(1);
      end else begin
        if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + cthm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
      lfsr_q     <= cthm_pkg::LFSR_SEED;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      row_init_q <= row_init_d;
      lfsr_q     <= lfsr_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      done_q     <= s1_valid_q;
    end
  end

  // Hold the hit flag of the finished transaction for its done cycle
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      hit_q <= lookup_hit;
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

endmodule
